// File: sv/ssh_pkg.sv
package ssh_pkg;

	// mid queue and result buffer depths (powers of two)
	localparam int QDEPTH = 4;
	localparam int OUT_DEPTH = 2;

	// bisection widths
	localparam int UBITS = 16;
	localparam int MBITS = 15;

	localparam logic [16:0] FRAC_ONE = 17'd65536;

	typedef enum logic [1:0] {
		KIND_NONE    = 2'd0,
		KIND_OVERLAP = 2'd1,
		KIND_HIT     = 2'd2
	} kind_t;

	// sweep bisection accumulators
	typedef logic signed [107:0] g_t;
	typedef logic [83:0] p_t;
	// normalize bisection accumulators
	typedef logic signed [139:0] n_t;

	// classified pair, front to back
	typedef struct packed {
		kind_t kind;
		logic [2:0][32:0] d;
		logic [2:0][31:0] mv;
		logic [63:0] a;
		logic [65:0] b;
		logic [65:0] c;
	} job_t;

	// vector to normalize, sweep to normalize stage
	typedef struct packed {
		kind_t kind;
		logic [16:0] frac;
		logic [2:0][49:0] v;
	} vec_t;

	typedef struct packed {
		kind_t kind;
		logic [16:0] frac;
		logic [2:0][15:0] n;
	} res_t;

endpackage

// File: sv/swept_sphere_sphere_hit.sv
// channel  | handshake          | transfers on              | payload
// input    | push / full        | push && !full             | two spheres and a move, Q16.16
// result   | empty / pop        | pop && !empty             | fraction, normal, kind
//
// one transaction per cycle sustained while full stays low and the result buffer keeps being popped
// front: 5-stage classify pipeline (squares, dot product, discriminant test)
// back: entry stage, 16-stage fraction bisection, 3 vector stages, 3 square stages,
//   15-stage normalize bisection
// a 4-entry queue splits front and back, a 2-entry result buffer parts back from pop
// full rises only when the mid queue is full; the back holds while the result buffer is full
// arst_n clears valid bits, pointers and counts; no clearing pass
module swept_sphere_sphere_hit (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic signed [31:0] fixed_center_x,
	input logic signed [31:0] fixed_center_y,
	input logic signed [31:0] fixed_center_z,
	input logic [30:0] fixed_radius,
	input logic signed [31:0] mover_center_x,
	input logic signed [31:0] mover_center_y,
	input logic signed [31:0] mover_center_z,
	input logic [30:0] mover_radius,
	input logic signed [31:0] move_x,
	input logic signed [31:0] move_y,
	input logic signed [31:0] move_z,
	output logic empty,
	input logic pop,
	output logic [16:0] hit_fraction,
	output logic signed [15:0] contact_normal_x,
	output logic signed [15:0] contact_normal_y,
	output logic signed [15:0] contact_normal_z,
	output logic [1:0] hit_kind
);

	localparam int OW = $clog2(ssh_pkg::OUT_DEPTH);
	localparam int OCW = $clog2(ssh_pkg::OUT_DEPTH + 1);

	// front side
	logic qspace, qnonempty;
	logic fr_valid;
	ssh_pkg::job_t fr_job, q_job;

	// back side
	logic ben, qrd;
	logic sw_valid, nr_valid;
	ssh_pkg::vec_t sw_vec;
	ssh_pkg::res_t nr_res;

	// result buffer
	ssh_pkg::res_t obuf_q [ssh_pkg::OUT_DEPTH];
	logic [OW-1:0] owp_q, orp_q;
	logic [OCW-1:0] ocnt_q;
	logic owr, ord;

	// front stalls only when the mid queue has no room
	assign full = !qspace;

	ssh_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(qspace),
		.push(push),
		.fixed_center_x(fixed_center_x),
		.fixed_center_y(fixed_center_y),
		.fixed_center_z(fixed_center_z),
		.fixed_radius(fixed_radius),
		.mover_center_x(mover_center_x),
		.mover_center_y(mover_center_y),
		.mover_center_z(mover_center_z),
		.mover_radius(mover_radius),
		.move_x(move_x),
		.move_y(move_y),
		.move_z(move_z),
		.out_valid(fr_valid),
		.out_job(fr_job)
	);

	ssh_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr(fr_valid && qspace),
		.wdata(fr_job),
		.rd(qrd),
		.rdata(q_job),
		.nonempty(qnonempty),
		.space(qspace)
	);

	// back advances while the result buffer has a free slot
	assign ben = ocnt_q < OCW'(ssh_pkg::OUT_DEPTH);
	assign qrd = ben && qnonempty;

	ssh_sweep u_sweep (
		.clk(clk),
		.arst_n(arst_n),
		.en(ben),
		.in_valid(qnonempty),
		.in_job(q_job),
		.out_valid(sw_valid),
		.out_vec(sw_vec)
	);

	ssh_norm u_norm (
		.clk(clk),
		.arst_n(arst_n),
		.en(ben),
		.in_valid(sw_valid),
		.in_vec(sw_vec),
		.out_valid(nr_valid),
		.out_res(nr_res)
	);

	// result buffer: back writes, consumer pops
	assign owr = ben && nr_valid;
	assign ord = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q <= '0;
			orp_q <= '0;
			ocnt_q <= '0;
		end else begin
			if (owr) owp_q <= owp_q + OW'(1);
			if (ord) orp_q <= orp_q + OW'(1);
			ocnt_q <= ocnt_q + OCW'(owr) - OCW'(ord);
		end
	end

	always_ff @(posedge clk) begin
		if (owr) obuf_q[owp_q] <= nr_res;
	end

	assign empty = ocnt_q == '0;
	assign hit_fraction = obuf_q[orp_q].frac;
	assign contact_normal_x = $signed(obuf_q[orp_q].n[0]);
	assign contact_normal_y = $signed(obuf_q[orp_q].n[1]);
	assign contact_normal_z = $signed(obuf_q[orp_q].n[2]);
	assign hit_kind = obuf_q[orp_q].kind;

	// a miss carries fraction one and a zero normal
	a_miss_fields: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && hit_kind == ssh_pkg::KIND_NONE |-> hit_fraction == ssh_pkg::FRAC_ONE
		&& contact_normal_x == '0 && contact_normal_y == '0 && contact_normal_z == '0)
		else $error("miss transaction with nonzero fields");

	// overlap at start always reports fraction zero
	a_overlap_frac: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && hit_kind == ssh_pkg::KIND_OVERLAP |-> hit_fraction == '0)
		else $error("overlap transaction with nonzero fraction");

	// unit normal components stay within one
	a_normal_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> contact_normal_x <= 16'sd16384 && contact_normal_x >= -16'sd16384
		&& contact_normal_y <= 16'sd16384 && contact_normal_y >= -16'sd16384
		&& contact_normal_z <= 16'sd16384 && contact_normal_z >= -16'sd16384)
		else $error("normal component out of range");

endmodule

// File: sv/ssh_front.sv
module ssh_front (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic push,
	input logic signed [31:0] fixed_center_x,
	input logic signed [31:0] fixed_center_y,
	input logic signed [31:0] fixed_center_z,
	input logic [30:0] fixed_radius,
	input logic signed [31:0] mover_center_x,
	input logic signed [31:0] mover_center_y,
	input logic signed [31:0] mover_center_z,
	input logic [30:0] mover_radius,
	input logic signed [31:0] move_x,
	input logic signed [31:0] move_y,
	input logic signed [31:0] move_z,
	output logic out_valid,
	output ssh_pkg::job_t out_job
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [32:0] d_s1 [3];
	logic signed [31:0] mv_s1 [3];
	logic [31:0] r_s1;

	logic signed [32:0] d_s2 [3];
	logic signed [31:0] mv_s2 [3];
	logic signed [65:0] dd_s2 [3];
	logic signed [65:0] dm_s2 [3];
	logic [63:0] mm_s2 [3];
	logic [63:0] rr_s2;

	logic signed [32:0] d_s3 [3];
	logic signed [31:0] mv_s3 [3];
	logic [63:0] a_s3;
	logic [65:0] b_s3, c_s3;
	logic ov_s3, bneg_s3;

	logic signed [32:0] d_s4 [3];
	logic signed [31:0] mv_s4 [3];
	logic [63:0] a_s4;
	logic [65:0] b_s4, c_s4;
	logic ov_s4, bneg_s4, vx_s4;
	logic [65:0] bhh_s4, bhl_s4, bll_s4;
	logic [64:0] ahh_s4, ahl_s4, alh_s4, pll_s4;

	ssh_pkg::job_t job_s5;

	logic [65:0] sum_s;
	logic [63:0] sum_a;
	logic signed [66:0] sum_p;
	logic [131:0] b2, ac;
	ssh_pkg::kind_t kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// relative center and radius sum
	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= 33'(mover_center_x) - 33'(fixed_center_x);
			d_s1[1] <= 33'(mover_center_y) - 33'(fixed_center_y);
			d_s1[2] <= 33'(mover_center_z) - 33'(fixed_center_z);
			mv_s1[0] <= move_x;
			mv_s1[1] <= move_y;
			mv_s1[2] <= move_z;
			r_s1 <= 32'(fixed_radius) + 32'(mover_radius);
		end
	end

	// squares and dot product terms
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s2[i] <= d_s1[i];
				mv_s2[i] <= mv_s1[i];
				dd_s2[i] <= 66'(d_s1[i]) * 66'(d_s1[i]);
				dm_s2[i] <= 66'(d_s1[i]) * 66'(mv_s1[i]);
				mm_s2[i] <= $unsigned(64'(mv_s1[i]) * 64'(mv_s1[i]));
			end
			rr_s2 <= 64'(r_s1) * 64'(r_s1);
		end
	end

	always_comb begin
		sum_s = $unsigned(dd_s2[0]) + $unsigned(dd_s2[1]) + $unsigned(dd_s2[2]);
		sum_a = mm_s2[0] + mm_s2[1] + mm_s2[2];
		sum_p = 67'(dm_s2[0]) + 67'(dm_s2[1]) + 67'(dm_s2[2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s3[i] <= d_s2[i];
				mv_s3[i] <= mv_s2[i];
			end
			a_s3 <= sum_a;
			b_s3 <= 66'(-sum_p);
			c_s3 <= sum_s - {2'b00, rr_s2};
			ov_s3 <= sum_s <= {2'b00, rr_s2};
			bneg_s3 <= sum_p < 0;
		end
	end

	// partial products of b*b and a*c, vertex test
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s4[i] <= d_s3[i];
				mv_s4[i] <= mv_s3[i];
			end
			a_s4 <= a_s3;
			b_s4 <= b_s3;
			c_s4 <= c_s3;
			ov_s4 <= ov_s3;
			bneg_s4 <= bneg_s3;
			vx_s4 <= ((67'(a_s3) + 67'(c_s3)) < {b_s3, 1'b0}) || ({2'b00, a_s3} > b_s3);
			bhh_s4 <= 66'(b_s3[65:33]) * 66'(b_s3[65:33]);
			bhl_s4 <= 66'(b_s3[65:33]) * 66'(b_s3[32:0]);
			bll_s4 <= 66'(b_s3[32:0]) * 66'(b_s3[32:0]);
			ahh_s4 <= 65'(a_s3[63:32]) * 65'(c_s3[65:33]);
			ahl_s4 <= 65'(a_s3[63:32]) * 65'(c_s3[32:0]);
			alh_s4 <= 65'(a_s3[31:0]) * 65'(c_s3[65:33]);
			pll_s4 <= 65'(a_s3[31:0]) * 65'(c_s3[32:0]);
		end
	end

	always_comb begin
		b2 = (132'(bhh_s4) << 66) + (132'(bhl_s4) << 34) + 132'(bll_s4);
		ac = (132'(ahh_s4) << 65) + (132'(ahl_s4) << 32) + (132'(alh_s4) << 33)
			+ 132'(pll_s4);
		priority if (ov_s4) begin
			kind = ssh_pkg::KIND_OVERLAP;
		end else if (!bneg_s4 || b2 < ac || !vx_s4) begin
			kind = ssh_pkg::KIND_NONE;
		end else begin
			kind = ssh_pkg::KIND_HIT;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			job_s5.kind <= kind;
			for (int i = 0; i < 3; i++) begin
				job_s5.d[i] <= d_s4[i];
				job_s5.mv[i] <= mv_s4[i];
			end
			job_s5.a <= a_s4;
			job_s5.b <= b_s4;
			job_s5.c <= c_s4;
		end
	end

	assign out_valid = v_s5;
	assign out_job = job_s5;

endmodule

// File: sv/ssh_queue.sv
module ssh_queue (
	input logic clk,
	input logic arst_n,
	input logic wr,
	input ssh_pkg::job_t wdata,
	input logic rd,
	output ssh_pkg::job_t rdata,
	output logic nonempty,
	output logic space
);

	localparam int PW = $clog2(ssh_pkg::QDEPTH);
	localparam int CW = $clog2(ssh_pkg::QDEPTH + 1);

	ssh_pkg::job_t mem_q [ssh_pkg::QDEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + PW'(1);
			if (rd) rp_q <= rp_q + PW'(1);
			cnt_q <= cnt_q + CW'(wr) - CW'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	assign rdata = mem_q[rp_q];
	assign nonempty = cnt_q != '0;
	assign space = cnt_q < CW'(ssh_pkg::QDEPTH);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) wr |-> space)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) rd |-> nonempty)
		else $error("queue read while empty");

endmodule

// File: sv/ssh_sweep.sv
module ssh_sweep (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input ssh_pkg::job_t in_job,
	output logic out_valid,
	output ssh_pkg::vec_t out_vec
);

	localparam int NS = ssh_pkg::UBITS;

	typedef struct packed {
		ssh_pkg::job_t job;
		logic [NS-1:0] u;
		ssh_pkg::g_t g;
		ssh_pkg::p_t p;
	} bst_t;

	bst_t bis_q [NS+1];
	logic bv_q [NS+1];

	logic v_s1, v_s2, v_s3;
	ssh_pkg::job_t job_s1, job_s2;
	logic [NS-1:0] u_s1, u_s2;
	logic signed [48:0] mvu_s1 [3];
	logic signed [49:0] vh_s2 [3];
	ssh_pkg::vec_t vec_s3;

	logic dzero, hzero;
	ssh_pkg::vec_t vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bv_q[0] <= 1'b0;
		else if (en) bv_q[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bis_q[0].job <= in_job;
			bis_q[0].u <= '0;
			bis_q[0].g <= '0;
			bis_q[0].p <= '0;
		end
	end

	// one fraction bit per stage, largest bit first
	for (genvar i = 0; i < NS; i++) begin : g_bit
		localparam int K = NS - 1 - i;
		ssh_pkg::g_t t_g;
		ssh_pkg::p_t t_p;
		logic take;
		bst_t nxt;

		always_comb begin
			t_g = bis_q[i].g + (ssh_pkg::g_t'(bis_q[i].p) << (K + 1))
				+ (ssh_pkg::g_t'(bis_q[i].job.a) << (2 * K))
				- (ssh_pkg::g_t'(bis_q[i].job.b) << (K + 17));
			t_p = bis_q[i].p + (ssh_pkg::p_t'(bis_q[i].job.a) << K);
			take = ((t_g + (ssh_pkg::g_t'(bis_q[i].job.c) << 32)) >= 0)
				&& (t_p <= (ssh_pkg::p_t'(bis_q[i].job.b) << 16));
			nxt = bis_q[i];
			if (take) begin
				nxt.u = bis_q[i].u | (NS'(1) << K);
				nxt.g = t_g;
				nxt.p = t_p;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) bv_q[i+1] <= 1'b0;
			else if (en) bv_q[i+1] <= bv_q[i];
		end

		always_ff @(posedge clk) begin
			if (en) bis_q[i+1] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= bv_q[NS];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// mover offset at the fraction found
	always_ff @(posedge clk) begin
		if (en) begin
			job_s1 <= bis_q[NS].job;
			u_s1 <= bis_q[NS].u;
			for (int i = 0; i < 3; i++) begin
				mvu_s1[i] <= 49'($signed(bis_q[NS].job.mv[i]))
					* 49'($signed({1'b0, bis_q[NS].u}));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			job_s2 <= job_s1;
			u_s2 <= u_s1;
			for (int i = 0; i < 3; i++) begin
				vh_s2[i] <= (50'($signed(job_s1.d[i])) <<< 16) + 50'(mvu_s1[i]);
			end
		end
	end

	always_comb begin
		dzero = job_s2.d == '0;
		hzero = vh_s2[0] == '0 && vh_s2[1] == '0 && vh_s2[2] == '0;
		vec.kind = job_s2.kind;
		vec.frac = ssh_pkg::FRAC_ONE;
		vec.v = '0;
		unique case (job_s2.kind)
			ssh_pkg::KIND_OVERLAP: begin
				vec.frac = '0;
				for (int i = 0; i < 3; i++) begin
					vec.v[i] = dzero ? -50'($signed(job_s2.mv[i]))
						: 50'($signed(job_s2.d[i]));
				end
			end
			ssh_pkg::KIND_HIT: begin
				vec.frac = {1'b0, u_s2};
				for (int i = 0; i < 3; i++) begin
					vec.v[i] = hzero ? -50'($signed(job_s2.mv[i])) : vh_s2[i];
				end
			end
			default: begin
				vec.kind = ssh_pkg::KIND_NONE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) vec_s3 <= vec;
	end

	assign out_valid = v_s3;
	assign out_vec = vec_s3;

endmodule

// File: sv/ssh_norm.sv
module ssh_norm (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input ssh_pkg::vec_t in_vec,
	output logic out_valid,
	output ssh_pkg::res_t out_res
);

	localparam int NS = ssh_pkg::MBITS;

	typedef struct packed {
		ssh_pkg::kind_t kind;
		logic [16:0] frac;
		logic [2:0] neg;
		logic [2:0][131:0] rhs;
		logic [101:0] s;
		logic snz;
		logic [2:0][NS-1:0] m;
		logic [2:0][139:0] k2s;
		logic [2:0][139:0] ks;
	} nst_t;

	logic v_s1, v_s2;
	ssh_pkg::kind_t kind_s1, kind_s2;
	logic [16:0] frac_s1, frac_s2;
	logic [2:0] neg_s1, neg_s2;
	logic [49:0] hh_s1 [3];
	logic [49:0] hl_s1 [3];
	logic [49:0] ll_s1 [3];
	logic [99:0] sq_s2 [3];

	nst_t st_q [NS+1];
	logic sv_q [NS+1];

	logic [49:0] mag [3];
	logic [101:0] ssum;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = in_vec.v[i][49] ? 50'(-$signed(in_vec.v[i])) : in_vec.v[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			sv_q[0] <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			sv_q[0] <= v_s2;
		end
	end

	// squares from half-width partial products
	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= in_vec.kind;
			frac_s1 <= in_vec.frac;
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= in_vec.v[i][49];
				hh_s1[i] <= 50'(mag[i][49:25]) * 50'(mag[i][49:25]);
				hl_s1[i] <= 50'(mag[i][49:25]) * 50'(mag[i][24:0]);
				ll_s1[i] <= 50'(mag[i][24:0]) * 50'(mag[i][24:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2 <= kind_s1;
			frac_s2 <= frac_s1;
			neg_s2 <= neg_s1;
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= (100'(hh_s1[i]) << 50) + (100'(hl_s1[i]) << 26)
					+ 100'(ll_s1[i]);
			end
		end
	end

	assign ssum = 102'(sq_s2[0]) + 102'(sq_s2[1]) + 102'(sq_s2[2]);

	// start with k = -1: k*k*s = s, k*s = -s
	always_ff @(posedge clk) begin
		if (en) begin
			st_q[0].kind <= kind_s2;
			st_q[0].frac <= frac_s2;
			st_q[0].neg <= neg_s2;
			st_q[0].s <= ssum;
			st_q[0].snz <= ssum != '0;
			st_q[0].m <= '0;
			for (int i = 0; i < 3; i++) begin
				st_q[0].rhs[i] <= 132'(sq_s2[i]) << 30;
				st_q[0].k2s[i] <= ssh_pkg::n_t'(ssum);
				st_q[0].ks[i] <= -ssh_pkg::n_t'(ssum);
			end
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_bit
		localparam int B = NS - 1 - i;
		nst_t nxt;

		always_comb begin
			ssh_pkg::n_t t;
			ssh_pkg::n_t sx;
			nxt = st_q[i];
			sx = ssh_pkg::n_t'(st_q[i].s);
			for (int j = 0; j < 3; j++) begin
				t = $signed(st_q[i].k2s[j]) + ($signed(st_q[i].ks[j]) <<< (B + 2))
					+ (sx <<< (2 * B + 2));
				// candidate above one is skipped once the top bit is set
				if (st_q[i].snz && !st_q[i].m[j][NS-1]
						&& t <= ssh_pkg::n_t'(st_q[i].rhs[j])) begin
					nxt.m[j][B] = 1'b1;
					nxt.k2s[j] = t;
					nxt.ks[j] = $signed(st_q[i].ks[j]) + (sx <<< (B + 1));
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sv_q[i+1] <= 1'b0;
			else if (en) sv_q[i+1] <= sv_q[i];
		end

		always_ff @(posedge clk) begin
			if (en) st_q[i+1] <= nxt;
		end
	end

	always_comb begin
		out_res.kind = st_q[NS].kind;
		out_res.frac = st_q[NS].frac;
		for (int j = 0; j < 3; j++) begin
			out_res.n[j] = st_q[NS].neg[j] ? 16'(-{1'b0, st_q[NS].m[j]})
				: {1'b0, st_q[NS].m[j]};
		end
	end

	assign out_valid = sv_q[NS];

endmodule
